// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ncc_pkg.sv
`timescale 1ns / 1ps

package ncc_pkg;

   // Sizes of the colour table and of the fields
   localparam int MAX_COLORS         = 6;
   localparam int NUM_COLORS_DEFAULT = 6;
   localparam int CHAN_W             = 8;
   localparam int COLOR_W            = 3 * CHAN_W;
   localparam int SQ_W               = 2 * CHAN_W;
   localparam int DIST_W             = 18;
   localparam int THR_W              = 9;
   localparam int IDX_W              = 3;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = COLOR_W;

   // Register indexes and result codes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 3'd6;
   localparam logic [IDX_W-1:0]       UNKNOWN_CODE    = 3'd6;
   localparam logic [THR_W-1:0]       THRESH_RESET    = 9'd50;
   localparam logic [DIST_W-1:0]      THRESH_SQ_RESET = DIST_W'(50 * 50);

   typedef struct packed {
      logic [CHAN_W-1:0] pix_blue;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_red;
   } pixel_type;

   typedef struct packed {
      logic [IDX_W-1:0]  color_index;
      logic [DIST_W-1:0] min_dist_sq;
   } result_type;

   // Absolute difference of two channel values
   function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // Squared distance between a pixel and a packed blue/green/red colour
   function automatic logic [DIST_W-1:0] color_dist(input pixel_type p,
                                                   input logic [COLOR_W-1:0] c);
      logic [CHAN_W-1:0] db;
      logic [CHAN_W-1:0] dg;
      logic [CHAN_W-1:0] dr;
      logic [SQ_W-1:0]   sb;
      logic [SQ_W-1:0]   sg;
      logic [SQ_W-1:0]   sr;
      db = chan_diff(p.pix_blue,  c[CHAN_W-1:0]);
      dg = chan_diff(p.pix_green, c[2*CHAN_W-1:CHAN_W]);
      dr = chan_diff(p.pix_red,   c[3*CHAN_W-1:2*CHAN_W]);
      sb = SQ_W'(db) * SQ_W'(db);
      sg = SQ_W'(dg) * SQ_W'(dg);
      sr = SQ_W'(dr) * SQ_W'(dr);
      return DIST_W'(sb) + DIST_W'(sg) + DIST_W'(sr);
   endfunction

endpackage

// File: hw/rtl/nearest_color_classifier_top.sv
`timescale 1ns / 1ps
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid / req_ready  pixel_type (blue, green, red)
//  rsp      out        rsp_valid / rsp_ready  result_type (color_index, min_dist_sq)
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
//  One pixel per clock unless rsp stalls; a pixel moves pixel reg, then result reg.
//  The pixel register feeds NUM_COLORS parallel distance units, a compare chain and
//  the threshold test, all combinational, landing in the result register.
//  Synchronous reset clears both stages, the colours to zero and the threshold to 50.
//  A stalled rsp holds its result while the pixel register can still take one more pixel.
//  csr is always ready; the squared threshold is computed once, at the write.

module nearest_color_classifier_top #(
   parameter int NUM_COLORS = ncc_pkg::NUM_COLORS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ncc_pkg::pixel_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ncc_pkg::result_type                rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ncc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ncc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ncc_pkg::*;

   logic [COLOR_W-1:0] color_ff [NUM_COLORS];
   logic [COLOR_W-1:0] color_in [NUM_COLORS];
   logic [DIST_W-1:0]  thr_sq_ff;
   logic [DIST_W-1:0]  thr_sq_in;
   logic [THR_W-1:0]   thr_val;

   pixel_type          pix_ff;
   pixel_type          pix_in;
   logic               pix_vld_ff;
   logic               pix_vld_in;
   result_type         res_ff;
   result_type         res_in;
   logic               res_vld_ff;
   logic               res_vld_in;
   logic               advance;
   logic               req_xfer;

   logic [DIST_W-1:0]  dist_sq [NUM_COLORS];
   logic [DIST_W-1:0]  best_dist;
   logic [IDX_W-1:0]   best_idx;

   // Accept every register write at once
   assign csr_ready = 1'b1;
   assign thr_val   = csr_data[THR_W-1:0];

   // Update the colour table and the squared threshold
   always_comb begin
      for (int k = 0; k < NUM_COLORS; k++) begin
         color_in[k] = color_ff[k];
         if (csr_valid && csr_index == CSR_INDEX_W'(k)) begin
            color_in[k] = csr_data;
         end
      end
      thr_sq_in = thr_sq_ff;
      if (csr_valid && csr_index == CSR_THRESHOLD) begin
         thr_sq_in = DIST_W'(thr_val) * DIST_W'(thr_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COLORS; k++) begin
            color_ff[k] <= '0;
         end
         thr_sq_ff <= THRESH_SQ_RESET;
      end else begin
         color_ff  <= color_in;
         thr_sq_ff <= thr_sq_in;
      end
   end

   // Advance the pipeline when the result stage is empty or being drained
   assign advance   = !res_vld_ff || rsp_ready;
   assign req_ready = !pix_vld_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      pix_in     = req_xfer ? req_data : pix_ff;
      pix_vld_in = req_xfer ? 1'b1 : (advance ? 1'b0 : pix_vld_ff);
      res_vld_in = advance ? pix_vld_ff : res_vld_ff;
   end

   // Measure the distance to each reference colour
   always_comb begin
      for (int k = 0; k < NUM_COLORS; k++) begin
         dist_sq[k] = color_dist(pix_ff, color_ff[k]);
      end
   end

   // Pick the nearest colour, lowest index on ties, then apply the threshold
   always_comb begin
      best_dist = dist_sq[0];
      best_idx  = '0;
      for (int k = 1; k < NUM_COLORS; k++) begin
         if (dist_sq[k] < best_dist) begin
            best_dist = dist_sq[k];
            best_idx  = IDX_W'(k);
         end
      end
      res_in = res_ff;
      if (advance && pix_vld_ff) begin
         res_in.min_dist_sq = best_dist;
         res_in.color_index = (best_dist > thr_sq_ff) ? UNKNOWN_CODE : best_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         pix_vld_ff <= pix_vld_in;
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      res_ff <= res_in;
   end

   assign rsp_valid = res_vld_ff;
   assign rsp_data  = res_ff;

endmodule

// File: hw/rtl/ncc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ncc_checker #(
   parameter int NUM_COLORS = ncc_pkg::NUM_COLORS_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ncc_pkg::result_type rsp_data
);
   import ncc_pkg::*;

   logic rsp_stall;
   logic index_ok;

   // Flag a held result and a legal index
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign index_ok  = (rsp_data.color_index < IDX_W'(NUM_COLORS)) ||
                      (rsp_data.color_index == UNKNOWN_CODE);

   // No result right after reset
   `ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // Index names a colour in use or the unknown code
   `ASSERT_CLK(a_index_range, clock, reset, rsp_valid |-> index_ok, "color_index out of range")

   // A stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "rsp dropped while stalled")

   // A stalled result keeps its payload
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_data), "rsp payload changed")

endmodule

bind nearest_color_classifier_top ncc_checker #(.NUM_COLORS(NUM_COLORS)) u_ncc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
